/* hdl/rsas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search: shared package
// Request codes, controller command and datapath status types.
// ----------------------------------------------------------------------------
package rsas_pkg;

  // Width of the element and target fields on the request channel.
  localparam int unsigned FIELD_W = 32;

  // Request kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Which index drives the store read port.
  typedef enum logic [1:0] {
    RD_START,
    RD_END,
    RD_MID,
    RD_SCAN
  } rd_sel_e;

  // Window edge update ordered by the controller.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_END_MID,
    UPD_START_MID,
    UPD_START_INC,
    UPD_SCAN_RISE,
    UPD_SCAN_FALL
  } upd_e;

  // Outcome of one window evaluation.
  typedef enum logic [2:0] {
    ACT_MISS,
    ACT_HIT,
    ACT_END_MID,
    ACT_START_MID,
    ACT_START_INC,
    ACT_SCAN_LO,
    ACT_SCAN_HI
  } act_e;

  typedef struct packed {
    logic    load;
    logic    srch_init;
    rd_sel_e rd_sel;
    logic    lat_lo;
    logic    lat_hi;
    logic    lat_mv;
    logic    scan_init;
    logic    scan_up;
    upd_e    upd;
  } cmd_t;

  typedef struct packed {
    logic win_empty;
    act_e act;
    logic scan_over;
    logic scan_break;
  } stat_t;

endpackage

/* hdl/rsas_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search: datapath
// Array store, fill count, window indices, fetched values and comparators.
// ----------------------------------------------------------------------------
module rsas_dp #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rsas_pkg::cmd_t                        cmd_i,
  input  logic signed [rsas_pkg::FIELD_W-1:0]   element_i,
  input  logic                                  last_element_i,
  input  logic signed [rsas_pkg::FIELD_W-1:0]   target_i,
  output rsas_pkg::stat_t                       stat_o,
  output logic                                  truncated_o
);
  import rsas_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 1;

  logic [DATA_WIDTH-1:0]        mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic [AW-1:0]                rd_addr;

  logic [CW-1:0]                count_q;
  logic                         new_arr_q;
  logic                         ovf_q;
  logic [CW-1:0]                base_w;

  logic signed [IW-1:0]         start_q, end_q, scan_i_q, scan_lim_q;
  logic                         scan_up_q;
  logic signed [IW:0]           sum_w;
  logic signed [IW-1:0]         mid_w, mid_m1, mid_p1;

  logic signed [DATA_WIDTH-1:0] tgt_q, lo_q, hi_q, mv_q;
  logic                         wrapped;
  act_e                         act;

  assign base_w = new_arr_q ? '0 : count_q;

  assign sum_w  = (IW+1)'(start_q) + (IW+1)'(end_q);
  assign mid_w  = sum_w[IW:1];
  assign mid_m1 = mid_w - IW'(1);
  assign mid_p1 = mid_w + IW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_START: rd_addr = start_q[AW-1:0];
      RD_END:   rd_addr = end_q[AW-1:0];
      RD_MID:   rd_addr = mid_w[AW-1:0];
      default:  rd_addr = scan_i_q[AW-1:0];
    endcase
  end

  // Store: one write port for loads, one registered read port for the search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (base_w < CW'(DEPTH))) begin
      mem_q[base_w[AW-1:0]] <= DATA_WIDTH'(element_i);
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Fetched values and target need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_init) tgt_q <= DATA_WIDTH'(target_i);
    if (cmd_i.lat_lo)    lo_q  <= rdata_q;
    if (cmd_i.lat_hi)    hi_q  <= rdata_q;
    if (cmd_i.lat_mv)    mv_q  <= rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      new_arr_q  <= 1'b1;
      ovf_q      <= 1'b0;
      start_q    <= '0;
      end_q      <= '0;
      scan_i_q   <= '0;
      scan_lim_q <= '0;
      scan_up_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        new_arr_q <= last_element_i;
        if (base_w < CW'(DEPTH)) begin
          count_q <= base_w + CW'(1);
          if (new_arr_q) ovf_q <= 1'b0;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.srch_init) begin
        start_q <= '0;
        end_q   <= IW'(count_q) - IW'(1);
      end
      if (cmd_i.scan_init) begin
        scan_up_q <= cmd_i.scan_up;
        if (cmd_i.scan_up) begin
          scan_i_q   <= mid_p1;
          scan_lim_q <= end_q;
        end else begin
          scan_i_q   <= start_q;
          scan_lim_q <= mid_m1;
        end
      end else if (cmd_i.rd_sel == RD_SCAN) begin
        scan_i_q <= scan_i_q + IW'(1);
      end
      case (cmd_i.upd)
        UPD_END_MID:   end_q   <= mid_m1;
        UPD_START_MID: start_q <= mid_p1;
        UPD_START_INC: start_q <= start_q + IW'(1);
        UPD_SCAN_RISE: begin
          if (scan_up_q) end_q <= mid_m1;
          else           start_q <= mid_p1;
        end
        UPD_SCAN_FALL: begin
          if (scan_up_q) start_q <= mid_p1;
          else           end_q <= mid_m1;
        end
        default: ;
      endcase
    end
  end

  // Window evaluation; the middle value is the read data in this cycle.
  assign wrapped = !(lo_q < hi_q);

  always_comb begin
    act = ACT_MISS;
    if ((tgt_q < lo_q) && (tgt_q > hi_q)) begin
      act = ACT_MISS;
    end else if ((tgt_q == lo_q) || (tgt_q == hi_q) || (tgt_q == rdata_q)) begin
      act = ACT_HIT;
    end else if (tgt_q > lo_q) begin
      if (tgt_q < rdata_q)                  act = ACT_END_MID;
      else if (!wrapped || rdata_q > hi_q)  act = ACT_START_MID;
      else if (rdata_q < hi_q)              act = ACT_END_MID;
      else                                  act = ACT_SCAN_LO;
    end else if (tgt_q < hi_q) begin
      if (tgt_q > rdata_q)                  act = ACT_START_INC;
      else if (wrapped && rdata_q > lo_q)   act = ACT_START_MID;
      else if (rdata_q < lo_q)              act = ACT_END_MID;
      else                                  act = ACT_SCAN_HI;
    end
  end

  assign stat_o.win_empty  = start_q > end_q;
  assign stat_o.act        = act;
  assign stat_o.scan_over  = scan_i_q > scan_lim_q;
  assign stat_o.scan_break = scan_up_q ? (rdata_q < mv_q) : (rdata_q > mv_q);
  assign truncated_o       = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_sel == RD_SCAN) |-> ((scan_i_q <= scan_lim_q) && (scan_i_q >= 0)))
    else $error("scan read outside its half window");

endmodule

/* hdl/rsas_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search: controller
// Sequences store reads, window updates and scans; registers the result.
// ----------------------------------------------------------------------------
module rsas_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            kind_i,
  input  rsas_pkg::stat_t stat_i,
  output rsas_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o,
  output logic            found_o
);
  import rsas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_HI,
    S_RD_MID,
    S_EVAL,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_e;

  state_e state_q, state_d;
  logic   done_q, found_q;
  logic   fin, fin_found;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    fin       = 1'b0;
    fin_found = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat_i.win_empty) begin
          fin = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_START;
          state_d      = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd_o.rd_sel = RD_END;
        cmd_o.lat_lo = 1'b1;
        state_d      = S_RD_MID;
      end
      S_RD_MID: begin
        cmd_o.rd_sel = RD_MID;
        cmd_o.lat_hi = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.lat_mv = 1'b1;
        state_d      = S_CHECK;
        case (stat_i.act)
          ACT_HIT: begin
            fin       = 1'b1;
            fin_found = 1'b1;
          end
          ACT_END_MID:   cmd_o.upd = UPD_END_MID;
          ACT_START_MID: cmd_o.upd = UPD_START_MID;
          ACT_START_INC: cmd_o.upd = UPD_START_INC;
          ACT_SCAN_LO: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end
          ACT_SCAN_HI: begin
            cmd_o.scan_init = 1'b1;
            cmd_o.scan_up   = 1'b1;
            state_d         = S_SCAN_RD;
          end
          default: fin = 1'b1;
        endcase
      end
      S_SCAN_RD: begin
        if (stat_i.scan_over) begin
          cmd_o.upd = UPD_SCAN_RISE;
          state_d   = S_CHECK;
        end else begin
          cmd_o.rd_sel = RD_SCAN;
          state_d      = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.scan_break) begin
          cmd_o.upd = UPD_SCAN_FALL;
          state_d   = S_CHECK;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (fin) found_q <= fin_found;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign found_o = found_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a search is still running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

endmodule

/* hdl/rotated_sorted_array_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search: top level
// Array store loaded element by element, searched for a target on request.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start_i high and busy_o low.
// kind_i low makes it a load: element_i is appended to the store in that
// same cycle, busy_o stays low and no result follows. last_element_i closes
// the array, so the next load begins a fresh one. Loads past DEPTH are
// dropped and remembered as truncation.
// kind_i high makes it a search for target_i. busy_o rises in the next cycle
// and the single result appears on found_o and truncated_o, marked by done_o
// high for exactly one cycle; busy_o is low again in that cycle, so a new
// request can be taken alongside the result. The receiver cannot stall.
// A search is paced by the single read port of the store: each window
// step takes three reads (start, end and middle) and an evaluation, and
// equal end values force a linear scan of a half window, reading and
// comparing one element at a time. An empty array answers not found.
// Reset empties the array and clears the truncation flag; the store itself
// is never cleared, since only entries of the current array are ever read.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_top #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                kind_i,
  input  logic signed [rsas_pkg::FIELD_W-1:0] element_i,
  input  logic                                last_element_i,
  input  logic signed [rsas_pkg::FIELD_W-1:0] target_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic                                truncated_o
);
  import rsas_pkg::*;

  // Commands from the sequencer and comparison status back from the datapath.
  cmd_t  cmd;
  stat_t stat;

  rsas_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .found_o (found_o)
  );

  // The truncation flag cannot change while a search runs, so it is shown
  // straight from the datapath alongside the registered found bit.
  rsas_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .element_i      (element_i),
    .last_element_i (last_element_i),
    .target_i       (target_i),
    .stat_o         (stat),
    .truncated_o    (truncated_o)
  );

endmodule
